// ===== design/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg: shared constants, types and helpers
// Residue width, prime modulus and the bit-serial modular step used by the
// modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // field widths
    localparam int BASE_W   = 30;
    localparam int EXPO_W   = 32;
    localparam int MOD_BITS = 30;

    // exponent bits actually scanned (low bits only)
    localparam int EXP_BITS  = 32;
    localparam int SCAN_BITS = (EXP_BITS < EXPO_W) ? EXP_BITS : EXPO_W;

    typedef logic [MOD_BITS-1:0] residue_t;
    typedef logic [MOD_BITS+1:0] wide_t;

    localparam residue_t MODULUS = 30'd998244353;

    // One multiplier bit of an MSB-first interleaved modular multiply:
    // returns (2*part + (sel ? addend : 0)) mod p, with part, addend < p.
    // The sum stays below 3p, so one of three candidates is the answer.
    function automatic residue_t mod_step(residue_t part, residue_t addend, logic sel);
        wide_t sum;
        wide_t sub1;
        wide_t sub2;
        sum  = {1'b0, part, 1'b0} + (sel ? {2'b00, addend} : '0);
        sub1 = sum - {2'b00, MODULUS};
        sub2 = sum - {1'b0, MODULUS, 1'b0};
        if (sum >= {1'b0, MODULUS, 1'b0})
            return sub2[MOD_BITS-1:0];
        else if (sum >= {2'b00, MODULUS})
            return sub1[MOD_BITS-1:0];
        else
            return sum[MOD_BITS-1:0];
    endfunction

    // 30-bit input is below 2p, so one conditional subtract reduces it
    function automatic residue_t reduce_base(logic [BASE_W-1:0] value);
        logic [BASE_W-1:0] diff;
        diff = value - MODULUS;
        if (value >= MODULUS)
            return diff;
        else
            return value;
    endfunction

endpackage

// ===== design/modular_exponentiation_core.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_core: base^exponent mod 998244353
// Right-to-left square-and-multiply with bit-serial modular multipliers.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays
// high until the result goes out. The result appears on power_result for
// exactly one cycle with done high, and the receiver cannot stall it, so it
// must capture it on that edge. The exponent is scanned LSB first, one bit
// per round (a load step plus a shift-add modular multiply over the 30
// residue bits, one multiplier bit per cycle), and the scan stops once the
// remaining exponent bits are all zero; a zero exponent goes straight from
// the load step to done. The 30-bit width of the residue and the
// one-bit-per-cycle multiplier set the length of a round. Square and
// multiply of one round run side by side on the same serial multiplier bits.
// ----------------------------------------------------------------------------
module modular_exponentiation_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mexp_pkg::BASE_W-1:0]   base_value,
    input  logic [mexp_pkg::EXPO_W-1:0]   exponent_value,
    output logic                          done,
    output logic [mexp_pkg::MOD_BITS-1:0] power_result
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(MOD_BITS);

    // sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;

    logic [1:0]           state_reg,  state_next;
    logic [CNT_W-1:0]     cnt_reg,    cnt_next;
    logic                 done_reg,   done_next;

    // datapath registers
    residue_t             pw_reg,     pw_next;     // current power of base
    residue_t             acc_reg,    acc_next;    // running result
    residue_t             msr_reg,    msr_next;    // serial multiplier bits (MSB first)
    residue_t             sq_reg,     sq_next;     // partial pw*pw
    residue_t             pr_reg,     pr_next;     // partial acc*pw
    residue_t             res_reg,    res_next;    // delivered result
    logic [SCAN_BITS-1:0] exp_reg,    exp_next;    // remaining exponent bits

    residue_t             sq_step;
    residue_t             pr_step;

    // Both products consume the same multiplier bit: pw scanned MSB first.
    assign sq_step = mod_step(sq_reg, pw_reg,  msr_reg[MOD_BITS-1]);
    assign pr_step = mod_step(pr_reg, acc_reg, msr_reg[MOD_BITS-1]);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        pw_next    = pw_reg;
        acc_next   = acc_reg;
        msr_next   = msr_reg;
        sq_next    = sq_reg;
        pr_next    = pr_reg;
        res_next   = res_reg;
        exp_next   = exp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pw_next    = reduce_base(base_value);
                    acc_next   = residue_t'(1);
                    exp_next   = exponent_value[SCAN_BITS-1:0];
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // either finish, or arm one round for the lowest exponent bit
                if (exp_reg == '0)
                begin
                    res_next   = acc_reg;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    msr_next   = pw_reg;
                    sq_next    = '0;
                    pr_next    = '0;
                    cnt_next   = CNT_W'(MOD_BITS - 1);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                sq_next  = sq_step;
                pr_next  = pr_step;
                msr_next = {msr_reg[MOD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // last multiplier bit: commit square and conditional product
                    pw_next = sq_step;
                    if (exp_reg[0])
                        acc_next = pr_step;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pw_reg  <= pw_next;
        acc_reg <= acc_next;
        msr_reg <= msr_next;
        sq_reg  <= sq_next;
        pr_reg  <= pr_next;
        res_reg <= res_next;
        exp_reg <= exp_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign power_result = res_reg;

`ifndef SYNTHESIS
    // delivered value is a proper residue
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (power_result < MODULUS))
        else $error("result not reduced");

    // an accepted request makes the core busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but core not busy");

    // result strobe lasts a single cycle and only once the core is free
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy ##1 !done))
        else $error("done strobe malformed");

    // operands of the serial multipliers stay reduced during a round
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (pw_reg < MODULUS && acc_reg < MODULUS
                                   && sq_reg < MODULUS && pr_reg < MODULUS))
        else $error("multiplier operand out of range");

    // a round always ends by committing back to the load step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && cnt_reg == '0) |=> (state_reg == ST_LOAD))
        else $error("round did not end in load step");
`endif

endmodule
